@@ rtl/ctfs_pkg.sv @@
// Shared types and constants for the colon tag field scanner.
package ctfs_pkg;

    // Byte codes the scanner cares about
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        MODE_HUNT    = 3'b001,
        MODE_STARTED = 3'b010,
        MODE_CONT    = 3'b100
    } t_mode;

    typedef struct packed {
        logic [31:0] tag_offset;
        logic [31:0] tag_length;
        logic [31:0] value_offset;
        logic [31:0] value_length;
        logic        no_fields;
        logic        last_of_record;
    } t_result;

    // Results raised by one byte: at most two
    typedef struct packed {
        logic    has_second;
        t_result first;
        t_result second;
    } t_bundle;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

@@ rtl/colon_tag_field_scanner.sv @@
// Top level of the colon tag field scanner.
// Takes one record byte per cycle when the bundle queue has room (four
// entries); the scanner decides on each byte combinationally, so a byte is
// accepted every cycle as long as results are drained. A field result is
// written to the queue when the byte that closes it transfers, then loaded
// into the output register before it shows on the output. A byte that
// closes two fields (a colon on the final byte) yields two results on
// consecutive output transfers; the output side moves one result per cycle
// while the consumer is ready. tlast on input marks the last byte of a
// record, tlast on output the last result of that record; tuser flags a
// record that held no tag. Offsets count every byte, carriage returns
// included, and saturate at 2^OFFSET_BITS - 1; outputs carry the low 32
// bits.
module colon_tag_field_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,     // allow_indented_tags
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,  // data_byte
    input  logic         i_s_axis_tlast,  // end_of_record
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tag_offset, tag_length, value_offset, value_length (32 bits each, low first)
    output logic [127:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser,  // no_fields
    output logic         o_m_axis_tlast   // last_of_record
);
    import ctfs_pkg::*;

    logic    accept;
    logic    push;
    logic    full;
    logic    q_valid;
    logic    q_pop;
    t_bundle bundle;
    t_bundle q_head;
    t_result result;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    ctfs_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_data_byte     (i_s_axis_tdata),
        .i_end_of_record (i_s_axis_tlast),
        .o_push          (push),
        .o_bundle        (bundle)
    );

    ctfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_full   (full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    ctfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {result.value_length, result.value_offset,
                             result.tag_length, result.tag_offset};
    assign o_m_axis_tuser = result.no_fields;
    assign o_m_axis_tlast = result.last_of_record;

endmodule

@@ rtl/ctfs_front.sv @@
// Byte scanner: tracks tag and value state and builds result bundles.
module ctfs_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_record,
    output logic             o_push,
    output ctfs_pkg::t_bundle o_bundle
);
    import ctfs_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

    logic          r_allow;
    t_mode         r_mode,      n_mode;
    logic [OB-1:0] r_pos,       n_pos;
    logic [OB-1:0] r_cand,      n_cand;
    logic          r_open,      n_open;
    logic [OB-1:0] r_tag_start, n_tag_start;
    logic [OB-1:0] r_tag_len,   n_tag_len;
    logic          r_vseen,     n_vseen;
    logic [OB-1:0] r_vfirst,    n_vfirst;
    logic [OB-1:0] r_vlast,     n_vlast;
    logic          r_sseen,     n_sseen;
    logic [OB-1:0] r_slast,     n_slast;

    logic    confirmed;
    logic    ignored;
    logic    ws;
    logic    emit_prev;
    t_result res_prev;
    t_result res_end;

    function automatic logic [31:0] to_out(input logic [OB-1:0] v);
        logic [OB+31:0] wide;
        wide = {32'd0, v};
        return wide[31:0];
    endfunction

    function automatic t_result make_result(
        input logic [OB-1:0] tag_start,
        input logic [OB-1:0] tag_len,
        input logic          seen,
        input logic [OB-1:0] first,
        input logic [OB-1:0] last,
        input logic [OB-1:0] field_end
    );
        t_result       r;
        logic [OB-1:0] d;
        logic [OB-1:0] vlen;
        d = last - first;
        vlen = (d == OFF_MAX) ? d : d + 1'b1;
        r.tag_offset     = to_out(tag_start);
        r.tag_length     = to_out(tag_len);
        r.value_offset   = seen ? to_out(first) : to_out(field_end);
        r.value_length   = seen ? to_out(vlen) : 32'd0;
        r.no_fields      = 1'b0;
        r.last_of_record = 1'b0;
        return r;
    endfunction

    assign ignored = (i_data_byte == CH_CR) || (i_data_byte == CH_VT);
    assign ws      = is_ws(i_data_byte);

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_cand      = r_cand;
        n_open      = r_open;
        n_tag_start = r_tag_start;
        n_tag_len   = r_tag_len;
        n_vseen     = r_vseen;
        n_vfirst    = r_vfirst;
        n_vlast     = r_vlast;
        n_sseen     = r_sseen;
        n_slast     = r_slast;
        confirmed   = 1'b0;
        res_end     = '0;

        if (!ignored) begin
            unique case (r_mode)
                MODE_HUNT: begin
                    if (!ws) begin
                        n_sseen = r_vseen;
                        n_slast = r_vlast;
                        n_cand  = r_pos;
                        n_mode  = MODE_STARTED;
                    end else if (!r_allow) begin
                        n_mode = MODE_CONT;
                    end
                end
                MODE_STARTED: begin
                    if (i_data_byte == CH_SPACE || i_data_byte == CH_TAB) begin
                        n_mode = MODE_CONT;
                    end else if (i_data_byte == CH_COLON) begin
                        confirmed = 1'b1;
                        n_mode    = MODE_CONT;
                    end else if (i_data_byte == CH_LF) begin
                        n_mode = MODE_HUNT;
                    end
                end
                default: begin
                    if (i_data_byte == CH_LF) begin
                        n_mode = MODE_HUNT;
                    end
                end
            endcase
        end

        // previous field closes at the candidate start; its value trims to the snapshot
        res_prev = make_result(r_tag_start, r_tag_len, r_sseen, r_vfirst, r_slast, r_cand);

        if (confirmed) begin
            n_open      = 1'b1;
            n_tag_start = r_cand;
            n_tag_len   = r_pos - r_cand;
            n_vseen     = 1'b0;
            n_vfirst    = '0;
            n_vlast     = '0;
        end else if (r_open && !ws) begin
            if (!r_vseen) begin
                n_vseen  = 1'b1;
                n_vfirst = r_pos;
            end
            n_vlast = r_pos;
        end

        n_pos = (r_pos == OFF_MAX) ? r_pos : r_pos + 1'b1;

        if (n_open) begin
            res_end = make_result(n_tag_start, n_tag_len, n_vseen, n_vfirst, n_vlast, n_pos);
        end else begin
            res_end.no_fields = 1'b1;
        end
        res_end.last_of_record = 1'b1;

        if (i_end_of_record) begin
            n_mode      = MODE_HUNT;
            n_pos       = '0;
            n_cand      = '0;
            n_open      = 1'b0;
            n_tag_start = '0;
            n_tag_len   = '0;
            n_vseen     = 1'b0;
            n_vfirst    = '0;
            n_vlast     = '0;
            n_sseen     = 1'b0;
            n_slast     = '0;
        end
    end

    assign emit_prev = confirmed && r_open;
    assign o_push    = i_accept && (emit_prev || i_end_of_record);

    always_comb begin
        o_bundle.has_second = emit_prev && i_end_of_record;
        o_bundle.first      = emit_prev ? res_prev : res_end;
        o_bundle.second     = res_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow <= 1'b1;
        end else if (i_cfg_we) begin
            r_allow <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HUNT;
            r_pos       <= '0;
            r_cand      <= '0;
            r_open      <= 1'b0;
            r_tag_start <= '0;
            r_tag_len   <= '0;
            r_vseen     <= 1'b0;
            r_vfirst    <= '0;
            r_vlast     <= '0;
            r_sseen     <= 1'b0;
            r_slast     <= '0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_cand      <= n_cand;
            r_open      <= n_open;
            r_tag_start <= n_tag_start;
            r_tag_len   <= n_tag_len;
            r_vseen     <= n_vseen;
            r_vfirst    <= n_vfirst;
            r_vlast     <= n_vlast;
            r_sseen     <= n_sseen;
            r_slast     <= n_slast;
        end
    end

endmodule

@@ rtl/ctfs_queue.sv @@
// Small bundle queue between the scanner and the output stage.
module ctfs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ctfs_pkg::t_bundle i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ctfs_pkg::t_bundle o_head
);
    import ctfs_pkg::*;

    t_bundle             r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/ctfs_back.sv @@
// Output stage: splits bundles into single results behind an output register.
module ctfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ctfs_pkg::t_bundle i_q_head,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ctfs_pkg::t_result o_result
);
    import ctfs_pkg::*;

    logic    r_out_valid, n_out_valid;
    t_result r_out,       n_out;
    logic    r_pend_valid, n_pend_valid;
    t_result r_pend,      n_pend;
    logic    load;

    assign load = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_q_pop      = 1'b0;
        if (load) begin
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_out_valid  = 1'b1;
                n_pend_valid = 1'b0;
            end else if (i_q_valid) begin
                n_out        = i_q_head.first;
                n_out_valid  = 1'b1;
                n_pend       = i_q_head.second;
                n_pend_valid = i_q_head.has_second;
                o_q_pop      = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
